// File: hw/rtl/sfmd_pkg.sv
// sfmd_pkg: shared constants, register indexes and structs of the state feedback motor drive.
// No dependencies; used by sfmd_drive and state_feedback_motor_drive.
package sfmd_pkg;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_GAIN_LEAN_ANGLE  = 3'd0;
    localparam logic [2:0] REG_GAIN_LEAN_RATE   = 3'd1;
    localparam logic [2:0] REG_GAIN_WHEEL_ANGLE = 3'd2;
    localparam logic [2:0] REG_GAIN_WHEEL_RATE  = 3'd3;
    localparam logic [2:0] REG_DEADBAND         = 3'd4;
    localparam logic [2:0] REG_SLOW_LIMIT       = 3'd5;
    localparam logic [2:0] REG_BRAKE_HOLD       = 3'd6;
    localparam logic [2:0] REG_REV_TIMEOUT      = 3'd7;

    // Register reset values
    localparam logic signed [31:0] RST_GAIN_LEAN_ANGLE  = -32'sd106700398;
    localparam logic signed [31:0] RST_GAIN_LEAN_RATE   = -32'sd33845561;
    localparam logic signed [31:0] RST_GAIN_WHEEL_ANGLE = -32'sd2317;
    localparam logic signed [31:0] RST_GAIN_WHEEL_RATE  = -32'sd138810;
    localparam logic [21:0]        RST_DEADBAND         = 22'd65536;
    localparam logic [30:0]        RST_SLOW_LIMIT       = 31'd26214;
    localparam logic [15:0]        RST_BRAKE_HOLD       = 16'd200;
    localparam logic [15:0]        RST_REV_TIMEOUT      = 16'd400;

    // Datapath constants
    localparam int PWM_BITS_DEFAULT = 8;
    localparam int DUTY_STEP        = 7;
    localparam int U_LIMIT          = 2621440;      // 40 V in Q16.16, equals 5 << 19
    localparam int U_HALF           = U_LIMIT / 2;  // rounding offset of the duty target
    localparam int DIV_SHIFT        = 19;           // power-of-two part of U_LIMIT
    localparam int RECIP_FIVE       = 3355444;      // ceil(2^24 / 5), exact below 2^22
    localparam int RECIP_SHIFT      = 24;

    // Drive configuration, held in the top level
    typedef struct packed {
        logic [21:0] deadband;
        logic [30:0] slow_limit;
        logic [15:0] brake_hold;
        logic [15:0] rev_timeout;
    } drive_cfg_t;

    // Per-item values handed to the drive update
    typedef struct packed {
        logic signed [22:0] u;
        logic [21:0]        mag;
        logic signed [31:0] speed;
        logic [31:0]        now;
    } drive_in_t;

    // Result fields of one tick
    typedef struct packed {
        logic [7:0]  duty;
        logic        brake;
        logic        forward;
        logic        pending;
    } drive_out_t;

endpackage

// File: hw/rtl/sfmd_mul.sv
// sfmd_mul: shared 32x32 signed multiplier with a registered product.
// Standalone; instantiated by state_feedback_motor_drive.
module sfmd_mul (
    input  logic               aclk,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [63:0] prod_reg
);

    logic signed [63:0] prod_next;

    // Full-width product, registered for the next step
    assign prod_next = 64'(op_a) * 64'(op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

// File: hw/rtl/sfmd_drive.sv
// sfmd_drive: deadband, reversal sequencing and duty slew; holds the drive state.
// Depends on sfmd_pkg; instantiated by state_feedback_motor_drive.
module sfmd_drive #(
    parameter int PWM_BITS = sfmd_pkg::PWM_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   upd,
    input  sfmd_pkg::drive_cfg_t   cfg,
    input  sfmd_pkg::drive_in_t    din,
    input  logic [PWM_BITS-1:0]    target,
    output sfmd_pkg::drive_out_t   dout
);

    localparam int SW = PWM_BITS + 2;
    localparam logic signed [SW-1:0] STEP_S = SW'(sfmd_pkg::DUTY_STEP);
    localparam logic signed [SW-1:0] MAX_S  = SW'((1 << PWM_BITS) - 1);
    localparam logic [PWM_BITS-1:0]  STEP_U = PWM_BITS'(sfmd_pkg::DUTY_STEP);

    logic [PWM_BITS-1:0] duty_reg, duty_next;
    logic                dir_reg, dir_next;
    logic                rev_reg, rev_next;
    logic [31:0]         start_reg, start_next;

    logic                in_band, desired, flip, hold_wait, slow, timed, hold_ok;
    logic                brake, pending;
    logic [31:0]         start_eff, elapsed, speed_mag;
    logic [PWM_BITS-1:0] base, dec;
    logic signed [SW-1:0] b_s, t_s, d1, d2;
    logic [PWM_BITS-1:0] slewed;
    logic [PWM_BITS+7:0] duty_wide;

    // Reversal decision
    always_comb begin
        in_band   = din.mag < cfg.deadband;
        desired   = ~din.u[22];
        flip      = desired != dir_reg;
        start_eff = rev_reg ? start_reg : din.now;
        elapsed   = din.now - start_eff;
        speed_mag = din.speed[31] ? 32'(-din.speed) : 32'(din.speed);
        slow      = speed_mag <= {1'b0, cfg.slow_limit};
        timed     = elapsed >= {16'b0, cfg.rev_timeout};
        hold_ok   = elapsed >= {16'b0, cfg.brake_hold};
        hold_wait = flip && (!hold_ok || (!slow && !timed));
    end

    // Slew toward the target: step up, then step down, then clamp
    always_comb begin
        base = flip ? '0 : duty_reg;
        b_s  = $signed({2'b00, base});
        t_s  = $signed({2'b00, target});
        d1   = (b_s < t_s) ? b_s + STEP_S : b_s;
        d2   = (d1 > t_s) ? d1 - STEP_S : d1;
        priority if (d2 < 0) begin
            slewed = '0;
        end else if (d2 > MAX_S) begin
            slewed = MAX_S[PWM_BITS-1:0];
        end else begin
            slewed = d2[PWM_BITS-1:0];
        end
        dec = (duty_reg < STEP_U) ? '0 : duty_reg - STEP_U;
    end

    // Next drive state and result flags
    always_comb begin
        duty_next  = duty_reg;
        dir_next   = dir_reg;
        rev_next   = rev_reg;
        start_next = start_reg;
        brake      = 1'b0;
        pending    = 1'b0;
        priority if (in_band) begin
            duty_next = dec;
            rev_next  = 1'b0;
        end else if (hold_wait) begin
            duty_next  = '0;
            rev_next   = 1'b1;
            start_next = start_eff;
            brake      = 1'b1;
            pending    = 1'b1;
        end else begin
            if (flip) begin
                dir_next   = desired;
                rev_next   = 1'b0;
                start_next = start_eff;
            end
            duty_next = slewed;
        end
    end

    // Advance the state once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg  <= '0;
            dir_reg   <= 1'b1;
            rev_reg   <= 1'b0;
            start_reg <= '0;
        end else if (upd) begin
            duty_reg  <= duty_next;
            dir_reg   <= dir_next;
            rev_reg   <= rev_next;
            start_reg <= start_next;
        end
    end

    // Duty field carries the low eight bits
    assign duty_wide    = {8'b0, duty_next};
    assign dout.duty    = duty_wide[7:0];
    assign dout.brake   = brake;
    assign dout.forward = dir_next;
    assign dout.pending = pending;

endmodule

// File: hw/rtl/state_feedback_motor_drive.sv
// state_feedback_motor_drive: top level with sequencer, accumulator and config registers.
// Depends on sfmd_pkg, sfmd_mul and sfmd_drive.
//
//   channel  | direction | handshake           | payload
//   s_       | in        | s_tvalid/s_tready   | s_tdata: 5 x 32-bit state and time
//   m_       | out       | m_tvalid/m_tready   | m_tdata: duty, flags, command
//   cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// From one acceptance to the next an item holds the block: the single 32x32
// multiplier runs four gain products (multiply then accumulate), then the duty
// scale and the reciprocal divide by five, with one state each for rounding,
// shifting and the drive update. m_tvalid and s_tready return together at the
// drive update. Reset is synchronous; gains and limits return to their
// defaults. A stalled result holds the update until m_tready.
module state_feedback_motor_drive #(
    parameter int PWM_BITS = sfmd_pkg::PWM_BITS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // lean_angle[31:0], lean_rate[63:32], wheel_angle[95:64],
    // motor_speed[127:96], now_ms[159:128]
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pwm_duty[7:0], brake_on[8], drive_forward[9], reversal_pending[10],
    // command_volts[33:11], zero[39:34]
    output logic [39:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_CMD  = 3'd3;
    localparam logic [2:0] ST_SCL  = 3'd4;
    localparam logic [2:0] ST_SHF  = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_DRV  = 3'd7;

    localparam logic signed [65:0] Q_LIMIT  = 66'(sfmd_pkg::U_LIMIT);
    localparam logic signed [22:0] U_POS    = 23'(sfmd_pkg::U_LIMIT);
    localparam logic signed [65:0] Q_HALF   = 66'sd32768;
    localparam logic signed [31:0] PWM_MAX  = 32'((1 << PWM_BITS) - 1);
    localparam logic [63:0]        T_ROUND  = 64'(sfmd_pkg::U_HALF);
    localparam logic signed [31:0] RECIP_OP = 32'(sfmd_pkg::RECIP_FIVE);

    // Configuration registers
    logic signed [31:0]   gain_reg [4];
    sfmd_pkg::drive_cfg_t dcfg_reg;

    // Sequencer and datapath registers
    logic [2:0]          state_reg, state_next;
    logic [1:0]          idx_reg, idx_next;
    logic signed [31:0]  x_reg [4];
    logic [31:0]         now_reg;
    logic signed [65:0]  acc_reg, acc_next;
    logic signed [22:0]  u_reg, u_next;
    logic [21:0]         mag_reg, mag_next;
    logic [21:0]         y_reg;
    logic                out_valid_reg;
    logic [39:0]         out_data_reg;

    logic signed [31:0]  op_a, op_b;
    logic signed [63:0]  prod_reg;
    logic signed [65:0]  q_round, q_neg;
    logic [63:0]         scaled;
    logic                s_fire, drv_go;
    logic [PWM_BITS-1:0] target;
    sfmd_pkg::drive_in_t  din;
    sfmd_pkg::drive_out_t dout;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign drv_go    = (state_reg == ST_DRV) && (!out_valid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg[0]          <= sfmd_pkg::RST_GAIN_LEAN_ANGLE;
            gain_reg[1]          <= sfmd_pkg::RST_GAIN_LEAN_RATE;
            gain_reg[2]          <= sfmd_pkg::RST_GAIN_WHEEL_ANGLE;
            gain_reg[3]          <= sfmd_pkg::RST_GAIN_WHEEL_RATE;
            dcfg_reg.deadband    <= sfmd_pkg::RST_DEADBAND;
            dcfg_reg.slow_limit  <= sfmd_pkg::RST_SLOW_LIMIT;
            dcfg_reg.brake_hold  <= sfmd_pkg::RST_BRAKE_HOLD;
            dcfg_reg.rev_timeout <= sfmd_pkg::RST_REV_TIMEOUT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sfmd_pkg::REG_GAIN_LEAN_ANGLE:  gain_reg[0] <= $signed(cfg_data);
                sfmd_pkg::REG_GAIN_LEAN_RATE:   gain_reg[1] <= $signed(cfg_data);
                sfmd_pkg::REG_GAIN_WHEEL_ANGLE: gain_reg[2] <= $signed(cfg_data);
                sfmd_pkg::REG_GAIN_WHEEL_RATE:  gain_reg[3] <= $signed(cfg_data);
                sfmd_pkg::REG_DEADBAND:         dcfg_reg.deadband    <= cfg_data[21:0];
                sfmd_pkg::REG_SLOW_LIMIT:       dcfg_reg.slow_limit  <= cfg_data[30:0];
                sfmd_pkg::REG_BRAKE_HOLD:       dcfg_reg.brake_hold  <= cfg_data[15:0];
                sfmd_pkg::REG_REV_TIMEOUT:      dcfg_reg.rev_timeout <= cfg_data[15:0];
            endcase
        end
    end

    // Select multiplier operands for the current step
    always_comb begin
        unique case (state_reg)
            ST_MUL: begin
                op_a = gain_reg[idx_reg];
                op_b = x_reg[idx_reg];
            end
            ST_SCL: begin
                op_a = $signed({10'b0, mag_reg});
                op_b = PWM_MAX;
            end
            default: begin
                op_a = $signed({10'b0, y_reg});
                op_b = RECIP_OP;
            end
        endcase
    end

    sfmd_mul u_mul (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    // Round the sum to Q16.16, negate and clamp
    always_comb begin
        q_round = (acc_reg + Q_HALF) >>> 16;
        q_neg   = -q_round;
        priority if (q_round < -Q_LIMIT) begin
            u_next = U_POS;
        end else if (q_round > Q_LIMIT) begin
            u_next = -U_POS;
        end else begin
            u_next = q_neg[22:0];
        end
        mag_next = u_next[22] ? 22'(-u_next) : u_next[21:0];
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_MUL;
                    idx_next   = '0;
                    acc_next   = '0;
                end
            end
            ST_MUL: state_next = ST_ACC;
            ST_ACC: begin
                acc_next = acc_reg + 66'(prod_reg);
                if (idx_reg == 2'd3) begin
                    state_next = ST_CMD;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_CMD: state_next = ST_SCL;
            ST_SCL: state_next = ST_SHF;
            ST_SHF: state_next = ST_DIV;
            ST_DIV: state_next = ST_DRV;
            ST_DRV: begin
                if (drv_go) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Datapath registers
    assign scaled = 64'(prod_reg) + T_ROUND;

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (s_fire) begin
            x_reg[0] <= $signed(s_tdata[31:0]);
            x_reg[1] <= $signed(s_tdata[63:32]);
            x_reg[2] <= $signed(s_tdata[95:64]);
            x_reg[3] <= $signed(s_tdata[127:96]);
            now_reg  <= s_tdata[159:128];
        end
        if (state_reg == ST_CMD) begin
            u_reg   <= u_next;
            mag_reg <= mag_next;
        end
        if (state_reg == ST_SHF) begin
            y_reg <= scaled[sfmd_pkg::DIV_SHIFT +: 22];
        end
    end

    // Drive update
    assign target    = prod_reg[sfmd_pkg::RECIP_SHIFT +: PWM_BITS];
    assign din.u     = u_reg;
    assign din.mag   = mag_reg;
    assign din.speed = x_reg[3];
    assign din.now   = now_reg;

    sfmd_drive #(
        .PWM_BITS (PWM_BITS)
    ) u_drive (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (drv_go),
        .cfg     (dcfg_reg),
        .din     (din),
        .target  (target),
        .dout    (dout)
    );

    // Output register: load on update, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (drv_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (drv_go) begin
            out_data_reg <= {6'b0, u_reg, dout.pending, dout.forward, dout.brake, dout.duty};
        end
    end

`ifndef SYNTHESIS
    // Busy once an item has been accepted
    assert property (@(posedge aclk) disable iff (!aresetn) s_fire |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // Waiting in a reversal means brake on and zero duty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[10]) |-> (out_data_reg[8] && out_data_reg[7:0] == 8'd0))
        else $error("pending reversal without brake or with nonzero duty");

    // Command stays within the clamp
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ($signed(out_data_reg[33:11]) <= U_POS
                           && $signed(out_data_reg[33:11]) >= -U_POS))
        else $error("command outside the clamp range");
`endif

endmodule
